// ===== sv/amgs_pkg.sv =====
package amgs_pkg;

   // Default size of the vertex matrix.
   localparam int MAX_VERTICES_DEFAULT = 64;

   // Vertex count register.
   localparam int                  CSR_WIDTH = 7;
   localparam logic [CSR_WIDTH-1:0] CSR_RESET = 7'd64;

   // Command codes carried by a request word.
   typedef enum logic [2:0] {
      CMD_INSERT = 3'd0,
      CMD_REMOVE = 3'd1,
      CMD_TEST   = 3'd2,
      CMD_DEGREE = 3'd3,
      CMD_BEST   = 3'd4
   } cmd_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW_A,
      ST_ROW_B,
      ST_DEGREE,
      ST_SCAN,
      ST_REPLY
   } state_type;

endpackage

// ===== sv/amgs_popcount.sv =====
module amgs_popcount #(
   parameter int WIDTH = amgs_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [WIDTH-1:0]             in_bits,
   output logic                         out_valid,
   output logic [$clog2(WIDTH+1)-1:0]   out_count
);

   localparam int CW     = $clog2(WIDTH + 1);
   localparam int LEVELS = $clog2(WIDTH);
   localparam int PADW   = 1 << LEVELS;

   logic [PADW-1:0] pad_bits;
   logic [CW-1:0]   tree_ff [PADW-1];
   logic [LEVELS-1:0] vld_ff;

   assign pad_bits = PADW'(in_bits);

   // Adder tree, one register per level. Level lv starts at PADW - (PADW >> lv).
   always_ff @(posedge clock) begin
      for (int lv = 0; lv < LEVELS; lv++) begin
         for (int i = 0; i < PADW / 2; i++) begin
            if (i < (PADW >> (lv + 1))) begin
               if (lv == 0) begin
                  tree_ff[i] <= CW'(pad_bits[2*i]) + CW'(pad_bits[2*i+1]);
               end else begin
                  tree_ff[PADW - (PADW >> lv) + i] <=
                     tree_ff[PADW - (PADW >> (lv - 1)) + 2*i] +
                     tree_ff[PADW - (PADW >> (lv - 1)) + 2*i + 1];
               end
            end
         end
      end
   end

   // Valid travels alongside the tree levels.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < LEVELS; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[LEVELS-1];
   assign out_count = tree_ff[PADW-2];

endmodule

// ===== sv/adjacency_matrix_graph_store.sv =====
// Channel   Direction  Handshake          Word
// req_      in         valid / stall      cmd, vertex_a, vertex_b
// rsp_      out        valid / stall      edge_present, degree_count, best_vertex, bad_index
// csr_      in         valid / ready      vertex count
//
// A test edge reads a bit of row a; insert and remove then write both symmetric rows in turn
// through the single write port of the row memory. A degree goes through the registered
// popcount tree; the most-connected scan reads one row a cycle and feeds each to the tree.
// Bad or unknown words go straight to the reply.
// Reset is synchronous; per-row valid flops make the whole matrix read as cleared at once.
// A stalled result sits in the output register while the controller waits to load it.
module adjacency_matrix_graph_store #(
   parameter int MAX_VERTICES = amgs_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [2:0]                            req_cmd,
   input  logic [$clog2(MAX_VERTICES)-1:0]       req_vertex_a,
   input  logic [$clog2(MAX_VERTICES)-1:0]       req_vertex_b,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_edge_present,
   output logic [$clog2(MAX_VERTICES+1)-1:0]     rsp_degree_count,
   output logic [$clog2(MAX_VERTICES)-1:0]       rsp_best_vertex,
   output logic                                  rsp_bad_index,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [amgs_pkg::CSR_WIDTH-1:0]        csr_data
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   // Row memory and per-row valid flags.
   logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] row_vld_ff;

   amgs_pkg::state_type state_ff, state_in;

   logic [amgs_pkg::CSR_WIDTH-1:0] count_ff;
   logic [CW-1:0]                  act_n;
   logic [MAX_VERTICES-1:0]        col_mask;

   logic [2:0]  cmd_ff, cmd_in;
   logic [VW-1:0] a_ff, a_in, b_ff, b_in;

   logic        rd_a_en, rd_b_en;
   logic [VW-1:0] rd_a_addr, rd_b_addr;
   logic [MAX_VERTICES-1:0] rd_a_ff, rd_b_ff;
   logic        rd_a_live_ff, rd_b_live_ff;
   logic [MAX_VERTICES-1:0] row_a, row_b, row_mod;

   logic        wr_en;
   logic [VW-1:0] wr_addr;
   logic [MAX_VERTICES-1:0] wr_row;

   logic        pc_feed_ff, pc_feed_in;
   logic        pc_valid;
   logic [CW-1:0] pc_count;

   logic [CW-1:0] scan_addr_ff, scan_addr_in;
   logic [CW-1:0] ret_ff, ret_in;
   logic          scan_issue, scan_last;

   logic          res_bad_ff, res_bad_in;
   logic [CW-1:0] res_deg_ff, res_deg_in;
   logic [VW-1:0] res_best_ff, res_best_in;

   logic          rsp_valid_ff, rsp_load;
   logic          rsp_present_ff, rsp_present_in;
   logic [CW-1:0] rsp_deg_ff, rsp_deg_in;
   logic [VW-1:0] rsp_best_ff, rsp_best_in;
   logic          rsp_bad_ff, rsp_bad_in;

   logic req_accept, a_ok, b_ok, out_free;

   // Active vertex count, clipped to the matrix size.
   always_comb begin
      if (32'(count_ff) > MAX_VERTICES) begin
         act_n = CW'(MAX_VERTICES);
      end else begin
         act_n = CW'(count_ff);
      end
   end

   // Columns at or beyond the active count are ignored.
   always_comb begin
      for (int c = 0; c < MAX_VERTICES; c++) begin
         col_mask[c] = (CW'(c) < act_n);
      end
   end

   assign req_stall  = (state_ff != amgs_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign a_ok       = (CW'(req_vertex_a) < act_n);
   assign b_ok       = (CW'(req_vertex_b) < act_n);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   // Rows that were never written read as cleared.
   assign row_a = rd_a_live_ff ? rd_a_ff : '0;
   assign row_b = rd_b_live_ff ? rd_b_ff : '0;

   assign scan_issue = (state_ff == amgs_pkg::ST_SCAN) && (scan_addr_ff < act_n);
   assign scan_last  = (ret_ff == CW'(act_n - CW'(1)));

   amgs_popcount #(
      .WIDTH(MAX_VERTICES)
   ) u_popcount (
      .clock    (clock),
      .reset    (reset),
      .in_valid (pc_feed_ff),
      .in_bits  (row_a & col_mask),
      .out_valid(pc_valid),
      .out_count(pc_count)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         amgs_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_cmd)
                  amgs_pkg::CMD_INSERT, amgs_pkg::CMD_REMOVE, amgs_pkg::CMD_TEST: begin
                     state_in = (a_ok && b_ok) ? amgs_pkg::ST_ROW_A : amgs_pkg::ST_REPLY;
                  end
                  amgs_pkg::CMD_DEGREE: begin
                     state_in = a_ok ? amgs_pkg::ST_DEGREE : amgs_pkg::ST_REPLY;
                  end
                  amgs_pkg::CMD_BEST: begin
                     state_in = (act_n != '0) ? amgs_pkg::ST_SCAN : amgs_pkg::ST_REPLY;
                  end
                  default: begin
                     state_in = amgs_pkg::ST_REPLY;
                  end
               endcase
            end
         end
         amgs_pkg::ST_ROW_A: begin
            if (cmd_ff != amgs_pkg::CMD_TEST) begin
               state_in = amgs_pkg::ST_ROW_B;
            end else if (out_free) begin
               state_in = amgs_pkg::ST_IDLE;
            end
         end
         amgs_pkg::ST_ROW_B: begin
            if (out_free) begin
               state_in = amgs_pkg::ST_IDLE;
            end
         end
         amgs_pkg::ST_DEGREE: begin
            if (pc_valid) begin
               state_in = amgs_pkg::ST_REPLY;
            end
         end
         amgs_pkg::ST_SCAN: begin
            if (pc_valid && scan_last) begin
               state_in = amgs_pkg::ST_REPLY;
            end
         end
         amgs_pkg::ST_REPLY: begin
            if (out_free) begin
               state_in = amgs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = amgs_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs of the controller: memory accesses, result loads, context updates.
   always_comb begin
      rd_a_en        = 1'b0;
      rd_a_addr      = req_vertex_a;
      rd_b_en        = 1'b0;
      rd_b_addr      = req_vertex_b;
      wr_en          = 1'b0;
      wr_addr        = a_ff;
      row_mod        = row_a;
      wr_row         = row_a;
      pc_feed_in     = 1'b0;
      cmd_in         = cmd_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      scan_addr_in   = scan_addr_ff;
      ret_in         = ret_ff;
      res_bad_in     = res_bad_ff;
      res_deg_in     = res_deg_ff;
      res_best_in    = res_best_ff;
      rsp_load       = 1'b0;
      rsp_present_in = 1'b0;
      rsp_deg_in     = '0;
      rsp_best_in    = '0;
      rsp_bad_in     = 1'b0;
      unique case (state_ff)
         amgs_pkg::ST_IDLE: begin
            if (req_accept) begin
               cmd_in       = req_cmd;
               a_in         = req_vertex_a;
               b_in         = req_vertex_b;
               scan_addr_in = '0;
               ret_in       = '0;
               res_deg_in   = '0;
               res_best_in  = '0;
               res_bad_in   = 1'b0;
               unique case (req_cmd)
                  amgs_pkg::CMD_INSERT, amgs_pkg::CMD_REMOVE, amgs_pkg::CMD_TEST: begin
                     rd_a_en    = a_ok && b_ok;
                     rd_b_en    = a_ok && b_ok;
                     res_bad_in = !(a_ok && b_ok);
                  end
                  amgs_pkg::CMD_DEGREE: begin
                     rd_a_en    = a_ok;
                     pc_feed_in = a_ok;
                     res_bad_in = !a_ok;
                  end
                  amgs_pkg::CMD_BEST: begin
                     res_bad_in = (act_n == '0);
                  end
                  default: begin
                     res_bad_in = 1'b0;
                  end
               endcase
            end
         end
         amgs_pkg::ST_ROW_A: begin
            // Test reads bit b of row a; updates rewrite row a with that bit changed.
            if (cmd_ff == amgs_pkg::CMD_TEST) begin
               rsp_load       = out_free;
               rsp_present_in = row_a[b_ff];
            end else begin
               row_mod        = row_a;
               row_mod[b_ff]  = (cmd_ff == amgs_pkg::CMD_INSERT);
               wr_en          = 1'b1;
               wr_addr        = a_ff;
               wr_row         = row_mod;
            end
         end
         amgs_pkg::ST_ROW_B: begin
            // The symmetric bit; rewriting while the result waits is harmless.
            row_mod       = row_b;
            row_mod[a_ff] = (cmd_ff == amgs_pkg::CMD_INSERT);
            wr_en         = 1'b1;
            wr_addr       = b_ff;
            wr_row        = row_mod;
            rsp_load      = out_free;
         end
         amgs_pkg::ST_DEGREE: begin
            if (pc_valid) begin
               res_deg_in = pc_count;
            end
         end
         amgs_pkg::ST_SCAN: begin
            // Rows go out one a cycle; counts return in the same order.
            if (scan_issue) begin
               rd_a_en      = 1'b1;
               rd_a_addr    = scan_addr_ff[VW-1:0];
               pc_feed_in   = 1'b1;
               scan_addr_in = scan_addr_ff + CW'(1);
            end
            if (pc_valid) begin
               ret_in = ret_ff + CW'(1);
               if (pc_count > res_deg_ff) begin
                  res_deg_in  = pc_count;
                  res_best_in = ret_ff[VW-1:0];
               end
            end
         end
         amgs_pkg::ST_REPLY: begin
            rsp_load    = out_free;
            rsp_deg_in  = res_deg_ff;
            rsp_best_in = res_best_ff;
            rsp_bad_in  = res_bad_ff;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // Row memory with registered reads on two ports and one write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_a_en) begin
         rd_a_ff      <= mem[rd_a_addr];
         rd_a_live_ff <= row_vld_ff[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff      <= mem[rd_b_addr];
         rd_b_live_ff <= row_vld_ff[rd_b_addr];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= amgs_pkg::ST_IDLE;
         row_vld_ff   <= '0;
         count_ff     <= amgs_pkg::CSR_RESET;
         pc_feed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pc_feed_ff <= pc_feed_in;
         if (wr_en) begin
            row_vld_ff[wr_addr] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            count_ff <= csr_data;
         end
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && rsp_stall);
      end
   end

   // Context and result registers.
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      scan_addr_ff <= scan_addr_in;
      ret_ff       <= ret_in;
      res_bad_ff   <= res_bad_in;
      res_deg_ff   <= res_deg_in;
      res_best_ff  <= res_best_in;
      if (rsp_load) begin
         rsp_present_ff <= rsp_present_in;
         rsp_deg_ff     <= rsp_deg_in;
         rsp_best_ff    <= rsp_best_in;
         rsp_bad_ff     <= rsp_bad_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_edge_present = rsp_present_ff;
   assign rsp_degree_count = rsp_deg_ff;
   assign rsp_best_vertex  = rsp_best_ff;
   assign rsp_bad_index    = rsp_bad_ff;

endmodule

// ===== sim/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import amgs_pkg::*;

   localparam int VERTS = MAX_VERTICES_DEFAULT;
   localparam int VW = $clog2(VERTS);
   localparam int DW = $clog2(VERTS + 1);
   localparam int HALF_PERIOD = 5;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL_CYCLES = 2 * VERTS + 32;
   localparam int SEGMENTS = 5;
   localparam int SEGMENT_WORDS = 110;
   localparam int PLAN_ROWS = 31;

   // Command codes that the block has no operation for.
   localparam logic [2:0] CMD_SPARE_FIRST = 3'(CMD_BEST) + 3'd1;
   localparam logic [2:0] CMD_SPARE_LAST = '1;

   localparam logic [VW-1:0] V_TOP = VW'(VERTS - 1);
   localparam logic [CSR_WIDTH-1:0] COUNT_TOP = '1;
   localparam logic [CSR_WIDTH-1:0] NO_COUNT = '0;

   typedef struct packed {
      logic          present;
      logic [DW-1:0] degree;
      logic [VW-1:0] best;
      logic          bad;
   } reply_type;

   localparam reply_type ZERO_REPLY = '0;
   localparam reply_type BAD_REPLY = '{present: 1'b0, degree: '0, best: '0, bad: 1'b1};
   localparam reply_type PRESENT_REPLY = '{present: 1'b1, degree: '0, best: '0, bad: 1'b0};

   typedef enum logic {
      ROW_WORD,
      ROW_COUNT
   } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [2:0]           cmd;
      logic [VW-1:0]        a;
      logic [VW-1:0]        b;
      logic [CSR_WIDTH-1:0] count;
      logic                 typed;
      reply_type            reply;
   } plan_row_type;

   // Directed words. Rows with typed set carry their reply; the rest go to the predictor.
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // Fresh matrix at the full vertex count.
      '{ROW_WORD, CMD_TEST, VW'(0), VW'(0), NO_COUNT, 1'b1, ZERO_REPLY},
      '{ROW_WORD, CMD_DEGREE, V_TOP, VW'(0), NO_COUNT, 1'b1, ZERO_REPLY},
      '{ROW_WORD, CMD_BEST, VW'(0), VW'(0), NO_COUNT, 1'b1, ZERO_REPLY},
      // Corner edge and a self loop on the last vertex.
      '{ROW_WORD, CMD_INSERT, VW'(0), V_TOP, NO_COUNT, 1'b1, ZERO_REPLY},
      '{ROW_WORD, CMD_INSERT, V_TOP, V_TOP, NO_COUNT, 1'b1, ZERO_REPLY},
      '{ROW_WORD, CMD_TEST, V_TOP, VW'(0), NO_COUNT, 1'b1, PRESENT_REPLY},
      '{ROW_WORD, CMD_DEGREE, V_TOP, VW'(0), NO_COUNT, 1'b0, ZERO_REPLY},
      '{ROW_WORD, CMD_BEST, VW'(0), VW'(0), NO_COUNT, 1'b0, ZERO_REPLY},
      '{ROW_WORD, CMD_REMOVE, V_TOP, VW'(0), NO_COUNT, 1'b1, ZERO_REPLY},
      '{ROW_WORD, CMD_TEST, VW'(0), V_TOP, NO_COUNT, 1'b1, ZERO_REPLY},
      // Unused command codes leave everything alone.
      '{ROW_WORD, CMD_SPARE_FIRST, V_TOP, V_TOP, NO_COUNT, 1'b1, ZERO_REPLY},
      '{ROW_WORD, CMD_SPARE_LAST, VW'(42), VW'(21), NO_COUNT, 1'b1, ZERO_REPLY},
      '{ROW_WORD, CMD_INSERT, VW'(9), VW'(12), NO_COUNT, 1'b1, ZERO_REPLY},
      '{ROW_WORD, CMD_INSERT, VW'(5), VW'(9), NO_COUNT, 1'b1, ZERO_REPLY},
      // Reduced count: out of range indexes, and columns past the count are ignored.
      '{ROW_COUNT, 3'(CMD_INSERT), VW'(0), VW'(0), CSR_WIDTH'(10), 1'b0, ZERO_REPLY},
      '{ROW_WORD, CMD_INSERT, VW'(3), VW'(12), NO_COUNT, 1'b1, BAD_REPLY},
      '{ROW_WORD, CMD_TEST, VW'(10), VW'(0), NO_COUNT, 1'b1, BAD_REPLY},
      '{ROW_WORD, CMD_DEGREE, VW'(10), VW'(0), NO_COUNT, 1'b1, BAD_REPLY},
      '{ROW_WORD, CMD_REMOVE, VW'(0), V_TOP, NO_COUNT, 1'b1, BAD_REPLY},
      '{ROW_WORD, CMD_DEGREE, VW'(9), VW'(0), NO_COUNT, 1'b0, ZERO_REPLY},
      '{ROW_WORD, CMD_INSERT, VW'(9), VW'(9), NO_COUNT, 1'b1, ZERO_REPLY},
      '{ROW_WORD, CMD_BEST, VW'(0), VW'(0), NO_COUNT, 1'b0, ZERO_REPLY},
      // Zero count: every real command is out of range.
      '{ROW_COUNT, 3'(CMD_INSERT), VW'(0), VW'(0), NO_COUNT, 1'b0, ZERO_REPLY},
      '{ROW_WORD, CMD_BEST, VW'(0), VW'(0), NO_COUNT, 1'b1, BAD_REPLY},
      '{ROW_WORD, CMD_INSERT, VW'(0), VW'(0), NO_COUNT, 1'b1, BAD_REPLY},
      '{ROW_WORD, CMD_SPARE_LAST, VW'(0), VW'(0), NO_COUNT, 1'b1, ZERO_REPLY},
      // Oversized count clips to the matrix size, so hidden bits count again.
      '{ROW_COUNT, 3'(CMD_INSERT), VW'(0), VW'(0), COUNT_TOP, 1'b0, ZERO_REPLY},
      '{ROW_WORD, CMD_DEGREE, VW'(9), VW'(0), NO_COUNT, 1'b0, ZERO_REPLY},
      '{ROW_WORD, CMD_BEST, VW'(0), VW'(0), NO_COUNT, 1'b0, ZERO_REPLY},
      // Single vertex.
      '{ROW_COUNT, 3'(CMD_INSERT), VW'(0), VW'(0), CSR_WIDTH'(1), 1'b0, ZERO_REPLY},
      '{ROW_WORD, CMD_TEST, VW'(0), VW'(1), NO_COUNT, 1'b1, BAD_REPLY}
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [2:0]           req_cmd;
   logic [VW-1:0]        req_vertex_a;
   logic [VW-1:0]        req_vertex_b;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_edge_present;
   logic [DW-1:0]        rsp_degree_count;
   logic [VW-1:0]        rsp_best_vertex;
   logic                 rsp_bad_index;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_WIDTH-1:0] csr_data;

   // Predictor state: the adjacency rows and the vertex count register.
   logic [VERTS-1:0]     graph_rows [VERTS];
   logic [CSR_WIDTH-1:0] vertex_limit;
   reply_type            pending_replies [$];

   int failures = 0;
   int words_sent = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_grants = 0;
   int hold_taken = 0;
   int hold_left = 0;

   adjacency_matrix_graph_store #(
      .MAX_VERTICES(VERTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_vertex_a(req_vertex_a),
      .req_vertex_b(req_vertex_b),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_edge_present(rsp_edge_present),
      .rsp_degree_count(rsp_degree_count),
      .rsp_best_vertex(rsp_best_vertex),
      .rsp_bad_index(rsp_bad_index),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // The register value is clipped to the matrix size.
   function automatic int active_vertices();
      return (int'(vertex_limit) > VERTS) ? VERTS : int'(vertex_limit);
   endfunction

   // A degree counts the set bits of a row over the first n columns.
   function automatic int row_degree(int row, int n);
      logic [VERTS-1:0] mask;
      mask = ~({VERTS{1'b1}} << n);
      return $countones(graph_rows[row] & mask);
   endfunction

   // Applies one word to the predicted matrix and returns the reply it yields.
   function automatic reply_type graph_apply(logic [2:0] cmd, logic [VW-1:0] a,
                                             logic [VW-1:0] b);
      reply_type r;
      int n;
      int d;
      r = '0;
      n = active_vertices();
      case (cmd)
         CMD_INSERT, CMD_REMOVE, CMD_TEST: begin
            if (int'(a) >= n || int'(b) >= n) begin
               r.bad = 1'b1;
            end else if (cmd == CMD_INSERT) begin
               graph_rows[a][b] = 1'b1;
               graph_rows[b][a] = 1'b1;
            end else if (cmd == CMD_REMOVE) begin
               graph_rows[a][b] = 1'b0;
               graph_rows[b][a] = 1'b0;
            end else begin
               r.present = graph_rows[a][b];
            end
         end
         CMD_DEGREE: begin
            if (int'(a) >= n) begin
               r.bad = 1'b1;
            end else begin
               r.degree = DW'(row_degree(int'(a), n));
            end
         end
         CMD_BEST: begin
            if (n == 0) begin
               r.bad = 1'b1;
            end else begin
               // Only a strictly higher degree moves the winner, so ties keep the lowest index.
               r.degree = DW'(row_degree(0, n));
               for (int v = 1; v < n; v++) begin
                  d = row_degree(v, n);
                  if (d > int'(r.degree)) begin
                     r.degree = DW'(d);
                     r.best = VW'(v);
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Mostly an index inside the active count, now and then any index at all.
   function automatic logic [VW-1:0] pick_vertex(int n);
      if (n > 0 && $urandom_range(99) < 88) begin
         return VW'($urandom_range(n - 1));
      end
      return VW'($urandom_range(VERTS - 1));
   endfunction

   // Offers one request word, with random idle cycles ahead of it, and records its reply.
   // Called and returns at a falling edge, with valid left high.
   task automatic send_word(input logic [2:0] cmd, input logic [VW-1:0] a,
                            input logic [VW-1:0] b, input logic typed = 1'b0,
                            input reply_type reply = '0);
      reply_type predicted;
      while (int'($urandom_range(99)) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_vertex_a <= a;
      req_vertex_b <= b;
      do @(posedge clock); while (req_stall);
      predicted = graph_apply(cmd, a, b);
      pending_replies.push_back(typed ? reply : predicted);
      words_sent++;
      @(negedge clock);
   endtask

   // Stops offering words until every expected reply has come back.
   task automatic wait_for_replies();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_replies.size() != 0) @(negedge clock);
   endtask

   // Writes the vertex count while the block is idle.
   task automatic write_vertex_count(input logic [CSR_WIDTH-1:0] value);
      wait_for_replies();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      vertex_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One idling setting: several segments, each at its own vertex count.
   task automatic run_phase(input int send_pct, input int recv_pct, input bit with_hold);
      logic [CSR_WIDTH-1:0] count;
      logic [2:0]           cmd;
      int                   n;
      int                   v;
      int                   start;
      int                   pick;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: count = CSR_WIDTH'(VERTS);
            1: count = CSR_WIDTH'($urandom_range(12, 2));
            2: count = COUNT_TOP;
            3: count = CSR_WIDTH'($urandom_range((1 << CSR_WIDTH) - 1));
            default: count = CSR_WIDTH'($urandom_range(2));
         endcase
         write_vertex_count(count);
         n = active_vertices();
         if (with_hold && seg == 0) begin
            hold_grants++;
         end
         start = words_sent;

         // Star fill: connect one vertex to every vertex, then ask its degree and the winner.
         if (n > 0 && (n == VERTS || $urandom_range(2) == 0)) begin
            v = int'($urandom_range(n - 1));
            for (int j = 0; j < n; j++) begin
               if ($urandom_range(1) == 0) begin
                  send_word(CMD_INSERT, VW'(v), VW'(j));
               end else begin
                  send_word(CMD_INSERT, VW'(j), VW'(v));
               end
            end
            send_word(CMD_DEGREE, VW'(v), pick_vertex(n));
            send_word(CMD_BEST, pick_vertex(n), pick_vertex(n));
         end

         // Random traffic, weighted toward edge updates and tests.
         while (words_sent - start < SEGMENT_WORDS) begin
            if (words_sent - start == SEGMENT_WORDS / 2 && $urandom_range(3) == 0) begin
               wait_for_replies();
            end
            pick = int'($urandom_range(99));
            if (pick < 34) begin
               cmd = CMD_INSERT;
            end else if (pick < 48) begin
               cmd = CMD_REMOVE;
            end else if (pick < 66) begin
               cmd = CMD_TEST;
            end else if (pick < 80) begin
               cmd = CMD_DEGREE;
            end else if (pick < 92) begin
               cmd = CMD_BEST;
            end else begin
               cmd = 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
            end
            send_word(cmd, pick_vertex(n), pick_vertex(n));
         end
      end
   endtask

   // Reply side stall: random, or held high for a long stretch when asked.
   always @(negedge clock) begin
      if (hold_grants != hold_taken) begin
         hold_taken = hold_grants;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (int'($urandom_range(99)) < recv_idle_pct);
      end
   end

   // Each accepted reply word is compared with the oldest expectation.
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected reply: present %0d degree %0d best %0d bad %0d",
                     $time, rsp_edge_present, rsp_degree_count, rsp_best_vertex,
                     rsp_bad_index);
            failures++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_edge_present !== want.present) begin
               $display("%0t: edge_present expected %0d actual %0d",
                        $time, want.present, rsp_edge_present);
               failures++;
            end
            if (rsp_degree_count !== want.degree) begin
               $display("%0t: degree_count expected %0d actual %0d",
                        $time, want.degree, rsp_degree_count);
               failures++;
            end
            if (rsp_best_vertex !== want.best) begin
               $display("%0t: best_vertex expected %0d actual %0d",
                        $time, want.best, rsp_best_vertex);
               failures++;
            end
            if (rsp_bad_index !== want.bad) begin
               $display("%0t: bad_index expected %0d actual %0d",
                        $time, want.bad, rsp_bad_index);
               failures++;
            end
         end
      end
   end

   // Watchdog: too many cycles in a row with no word moving on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = '0;
      req_vertex_a = '0;
      req_vertex_b = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      vertex_limit = CSR_RESET;
      for (int r = 0; r < VERTS; r++) begin
         graph_rows[r] = '0;
      end
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed words under the first idling setting.
      send_idle_pct = 13;
      recv_idle_pct = 68;
      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (PLAN[i].kind == ROW_COUNT) begin
            write_vertex_count(PLAN[i].count);
         end else begin
            send_word(PLAN[i].cmd, PLAN[i].a, PLAN[i].b, PLAN[i].typed, PLAN[i].reply);
         end
      end

      run_phase(13, 68, 1'b0);
      run_phase(68, 13, 1'b0);
      run_phase(0, 0, 1'b1);

      // Drain, then leave time for any stray reply to show up.
      wait_for_replies();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
